// ----- sv/wpsp_pkg.sv -----
package wpsp_pkg;

   localparam int unsigned MAX_SAMPLE_BYTES = 4;
   localparam int unsigned MAX_CHANNELS = 2;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] FMT_MIN_LEN = 32'd16;

   typedef enum logic [3:0] {
      PH_RIFF = 4'd0,
      PH_RLEN = 4'd1,
      PH_WAVE = 4'd2,
      PH_CID = 4'd3,
      PH_CLEN = 4'd4,
      PH_FMT = 4'd5,
      PH_SKIP = 4'd6,
      PH_DATA = 4'd7,
      PH_HALT = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_FORMAT = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_BAD_RIFF = 3'd1,
      ST_BAD_WAVE = 3'd2,
      ST_CHANNELS = 3'd3,
      ST_NOT_PCM = 3'd4,
      ST_SHORT_FMT = 3'd5,
      ST_NO_FMT = 3'd6,
      ST_WIDTH = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic first_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic channel;
      logic [31:0] sample_bytes;
      logic [2:0] status;
      logic [15:0] channel_count;
      logic [31:0] frame_rate;
      logic [15:0] frame_bytes;
      logic [15:0] sample_bits;
   } rsp_type;

   // per-sample byte count from align/channels; channels is 1 or 2 when used
   function automatic logic [15:0] bytes_per_sample(input logic [15:0] align,
                                                    input logic [15:0] chans);
      logic [15:0] r;
      begin
         if (chans == 16'd2) begin
            r = {1'b0, align[15:1]};
         end else if (chans == 16'd1) begin
            r = align;
         end else begin
            r = 16'd0;
         end
         return r;
      end
   endfunction

endpackage

// ----- sv/wpsp_stream_if.sv -----
interface wpsp_stream_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/wav_pcm_stream_parser_top.sv -----
// WAV PCM stream parser: takes one file byte per beat, one beat per cycle while rsp
// is ready, through a two-entry queue in front of a parser with an output register.
// A beat with first_byte set restarts parsing. Each byte gives at most one result
// beat: a sample, the format report once, or an error, after which bytes are dropped.
module wav_pcm_stream_parser_top
   import wpsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   wpsp_stream_if.sink   req,
   wpsp_stream_if.source rsp
);
   logic fifo_full, fifo_empty, p_ready;
   req_type q_data;

   assign req.ready = !fifo_full;

   wpsp_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(req.valid && !fifo_full), .push_data(req.data), .full(fifo_full),
      .pop(!fifo_empty && p_ready), .empty(fifo_empty), .pop_data(q_data)
   );

   wpsp_parser u_parser (
      .clock(clock), .reset(reset),
      .in_valid(!fifo_empty), .in_data(q_data), .in_ready(p_ready),
      .out_valid(rsp.valid), .out_data(rsp.data), .out_ready(rsp.ready)
   );
endmodule

// ----- sv/wpsp_fifo.sv -----
module wpsp_fifo
   import wpsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output req_type pop_data
);
   req_type mem_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("fifo overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("fifo underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("fifo count out of range");
`endif
endmodule

// ----- sv/wpsp_parser.sv -----
module wpsp_parser
   import wpsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);
   phase_type phase_ff, phase_in, ph;
   logic [2:0] fcnt_ff, fcnt_in;
   logic [31:0] fshift_ff, fshift_in;
   logic [31:0] cid_ff, cid_in;
   logic [31:0] left_ff, left_in;
   logic [4:0] foff_ff, foff_in;
   logic [15:0] comp_ff, comp_in, chans_ff, chans_in, align_ff, align_in, bits_ff, bits_in;
   logic [31:0] rate_ff, rate_in;
   logic seen_ff, seen_in, chn_ff, chn_in;
   logic [2:0] sidx_ff, sidx_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] per_ff, per_in;
   logic ov_ff, ov_in;
   rsp_type od_ff, od_in;

   logic take;
   assign in_ready = !ov_ff || out_ready;
   assign take = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_data = od_ff;

   always_comb begin
      logic [31:0] word, b32, lft;
      logic [2:0] si;
      logic [15:0] per;
      phase_in = phase_ff; fcnt_in = fcnt_ff; fshift_in = fshift_ff; cid_in = cid_ff;
      left_in = left_ff; foff_in = foff_ff; comp_in = comp_ff; chans_in = chans_ff;
      rate_in = rate_ff; align_in = align_ff; bits_in = bits_ff; seen_in = seen_ff;
      chn_in = chn_ff; sidx_in = sidx_ff; acc_in = acc_ff; per_in = per_ff;
      ov_in = ov_ff && !out_ready; od_in = od_ff;
      word = '0; si = '0; per = '0; lft = '0;
      b32 = {24'd0, in_data.byte_in};
      ph = phase_ff;
      if (take) begin
         od_in = '0;
         if (in_data.first_byte) begin
            ph = PH_RIFF; fcnt_in = '0; fshift_in = '0; cid_in = '0; left_in = '0;
            foff_in = '0; comp_in = '0; chans_in = '0; rate_in = '0; align_in = '0;
            bits_in = '0; seen_in = 1'b0; chn_in = 1'b0; sidx_in = '0; acc_in = '0;
            per_in = 16'd1;
         end else begin
            fcnt_in = fcnt_ff; fshift_in = fshift_ff;
         end
         phase_in = ph;
         unique case (ph)
            PH_RIFF, PH_RLEN, PH_WAVE, PH_CID, PH_CLEN: begin
               word = fshift_in | (b32 << {fcnt_in[1:0], 3'b000});
               fshift_in = word;
               fcnt_in = fcnt_in + 3'd1;
               if (fcnt_in == 3'd4) begin
                  fshift_in = '0;
                  fcnt_in = '0;
                  unique case (ph)
                     PH_RIFF: begin
                        if (word != TAG_RIFF) begin
                           phase_in = PH_HALT; ov_in = 1'b1;
                           od_in.kind = KIND_ERROR; od_in.status = ST_BAD_RIFF;
                        end else phase_in = PH_RLEN;
                     end
                     PH_RLEN: phase_in = PH_WAVE;
                     PH_WAVE: begin
                        if (word != TAG_WAVE) begin
                           phase_in = PH_HALT; ov_in = 1'b1;
                           od_in.kind = KIND_ERROR; od_in.status = ST_BAD_WAVE;
                        end else phase_in = PH_CID;
                     end
                     PH_CID: begin
                        cid_in = word; phase_in = PH_CLEN;
                     end
                     default: begin
                        left_in = word;
                        if (cid_ff == TAG_FMT && !seen_ff) begin
                           if (word < FMT_MIN_LEN) begin
                              phase_in = PH_HALT; ov_in = 1'b1;
                              od_in.kind = KIND_ERROR; od_in.status = ST_SHORT_FMT;
                           end else begin
                              foff_in = '0; phase_in = PH_FMT;
                           end
                        end else if (cid_ff == TAG_DATA) begin
                           if (!seen_ff) begin
                              phase_in = PH_HALT; ov_in = 1'b1;
                              od_in.kind = KIND_ERROR; od_in.status = ST_NO_FMT;
                           end else begin
                              chn_in = 1'b0; sidx_in = '0; acc_in = '0;
                              phase_in = (word != '0) ? PH_DATA : PH_CID;
                           end
                        end else begin
                           phase_in = (word != '0) ? PH_SKIP : PH_CID;
                        end
                     end
                  endcase
               end
            end
            PH_FMT: begin
               unique case (foff_ff)
                  5'd0: comp_in[7:0] = comp_ff[7:0] | in_data.byte_in;
                  5'd1: comp_in[15:8] = comp_ff[15:8] | in_data.byte_in;
                  5'd2: chans_in[7:0] = chans_ff[7:0] | in_data.byte_in;
                  5'd3: chans_in[15:8] = chans_ff[15:8] | in_data.byte_in;
                  5'd4: rate_in[7:0] = rate_ff[7:0] | in_data.byte_in;
                  5'd5: rate_in[15:8] = rate_ff[15:8] | in_data.byte_in;
                  5'd6: rate_in[23:16] = rate_ff[23:16] | in_data.byte_in;
                  5'd7: rate_in[31:24] = rate_ff[31:24] | in_data.byte_in;
                  5'd12: align_in[7:0] = align_ff[7:0] | in_data.byte_in;
                  5'd13: align_in[15:8] = align_ff[15:8] | in_data.byte_in;
                  5'd14: bits_in[7:0] = bits_ff[7:0] | in_data.byte_in;
                  5'd15: bits_in[15:8] = bits_ff[15:8] | in_data.byte_in;
                  default: ;
               endcase
               if (foff_ff < 5'd16) foff_in = foff_ff + 5'd1;
               lft = left_ff - 32'd1;
               left_in = lft;
               if (lft == '0) begin
                  phase_in = PH_CID;
                  per = bytes_per_sample(align_in, chans_in);
                  per_in = (per == 16'd0) ? 16'd1 : per;
                  ov_in = 1'b1;
                  if (chans_in == 16'd0 || chans_in > 16'(MAX_CHANNELS)) begin
                     phase_in = PH_HALT; od_in.kind = KIND_ERROR; od_in.status = ST_CHANNELS;
                  end else if (comp_in != 16'd1) begin
                     phase_in = PH_HALT; od_in.kind = KIND_ERROR; od_in.status = ST_NOT_PCM;
                  end else if (per == 16'd0 || per > 16'(MAX_SAMPLE_BYTES)) begin
                     phase_in = PH_HALT; od_in.kind = KIND_ERROR; od_in.status = ST_WIDTH;
                  end else begin
                     seen_in = 1'b1;
                     od_in.kind = KIND_FORMAT;
                     od_in.channel_count = chans_in;
                     od_in.frame_rate = rate_in;
                     od_in.frame_bytes = align_in;
                     od_in.sample_bits = bits_in;
                  end
               end
            end
            PH_SKIP: begin
               lft = left_ff - 32'd1;
               left_in = lft;
               if (lft == '0) phase_in = PH_CID;
            end
            PH_DATA: begin
               acc_in = acc_ff;
               if (!sidx_ff[2]) acc_in = acc_ff | (b32 << {sidx_ff[1:0], 3'b000});
               si = sidx_ff + 3'd1;
               sidx_in = si;
               if ({13'd0, si} >= per_ff || si == 3'd0) begin
                  ov_in = 1'b1;
                  od_in.kind = KIND_SAMPLE;
                  od_in.channel = chn_ff;
                  od_in.sample_bytes = acc_in;
                  acc_in = '0; sidx_in = '0;
                  chn_in = ({15'd0, chn_ff} + 16'd1 >= chans_ff) ? 1'b0 : !chn_ff;
               end
               lft = left_ff - 32'd1;
               left_in = lft;
               if (lft == '0) begin
                  acc_in = '0; sidx_in = '0; chn_in = 1'b0; phase_in = PH_CID;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF; fcnt_ff <= '0; fshift_ff <= '0; cid_ff <= '0;
         left_ff <= '0; foff_ff <= '0; comp_ff <= '0; chans_ff <= '0; rate_ff <= '0;
         align_ff <= '0; bits_ff <= '0; seen_ff <= 1'b0; chn_ff <= 1'b0;
         sidx_ff <= '0; acc_ff <= '0; per_ff <= 16'd1; ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; fcnt_ff <= fcnt_in; fshift_ff <= fshift_in; cid_ff <= cid_in;
         left_ff <= left_in; foff_ff <= foff_in; comp_ff <= comp_in; chans_ff <= chans_in;
         rate_ff <= rate_in; align_ff <= align_in; bits_ff <= bits_in; seen_ff <= seen_in;
         chn_ff <= chn_in; sidx_ff <= sidx_in; acc_ff <= acc_in; per_ff <= per_in;
         ov_ff <= ov_in;
      end
      od_ff <= od_in;
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result lost");
   a_halt_err: assert property (@(posedge clock) disable iff (reset)
      $rose(phase_ff == PH_HALT) |-> out_valid && out_data.kind == KIND_ERROR)
      else $error("halt without error");
   a_fcnt: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff < 3'd4) else $error("header byte count out of range");
`endif
endmodule
